### hdl/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define LGRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition at one edge implies a consequence at the next edge.
`define LGRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/lgrs_pkg.sv
// Types, constants and helper functions for the life generation row stream.
package lgrs_pkg;

  localparam int ROW_W       = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int COL_W       = 7;
  localparam int QDEPTH      = 3;
  localparam int QCNT_W      = 2;

  localparam logic [COL_W-1:0] COLUMNS_RESET = COL_W'(64);
  localparam logic [3:0]       BIRTH_COUNT   = 4'd3;
  localparam logic [3:0]       SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic [ROW_W-1:0] row_cells;
    logic             last_row;
  } row_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic             frame_end;
  } gen_item_t;

  // Masked bits that one column shows to its two neighbors.
  typedef struct packed {
    logic above;
    logic middle;
    logic below;
    logic kept;    // pending row bit, zero when nothing is pending
  } cell_bits_t;

  function automatic logic [3:0] count8(input logic [7:0] b);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + 4'(b[i]);
    end
    return s;
  endfunction

  function automatic logic life_rule(input logic [3:0] n, input logic alive);
    return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && alive);
  endfunction

endpackage

### hdl/lgrs_cell.sv
// One grid column: holds its above and pending bits and evaluates the life rule.
module lgrs_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                mask,
  input  logic                row_bit,
  input  logic                accept,
  input  logic                last,
  input  logic                mid_valid,
  input  lgrs_pkg::cell_bits_t left,
  input  lgrs_pkg::cell_bits_t right,
  output lgrs_pkg::cell_bits_t bits,
  output logic                res_a,
  output logic                res_b
);
  import lgrs_pkg::*;

  logic above;
  logic middle;
  logic [3:0] count_a;
  logic [3:0] count_b;

  always_comb begin
    bits.above  = above & mask;
    bits.middle = middle & mask;
    bits.below  = row_bit & mask;
    bits.kept   = bits.middle & mid_valid;
  end

  // Pending row with the new row below it.
  assign count_a = count8({left.above, bits.above, right.above,
                           left.middle, right.middle,
                           left.below, bits.below, right.below});
  assign res_a = life_rule(count_a, bits.middle) & mask;

  // New row with the pending row above and a dead row below.
  assign count_b = count8({left.kept, bits.kept, right.kept,
                           left.below, right.below, 3'b000});
  assign res_b = life_rule(count_b, bits.below) & mask;

  // Advance the stored pending bit as it was taken in, or clear both bits on a
  // last row; the width in force when the pending bit is next used masks it again.
  always_ff @(posedge clk) begin
    if (rst) begin
      above  <= 1'b0;
      middle <= 1'b0;
    end else if (accept) begin
      if (last) begin
        above  <= 1'b0;
        middle <= 1'b0;
      end else begin
        if (mid_valid) begin
          above <= middle;
        end
        middle <= bits.below;
      end
    end
  end

endmodule

### hdl/lgrs_out_queue.sv
// Three-entry shifting result queue that parts the input side from the output side.
module lgrs_out_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   push_n,
  input  lgrs_pkg::gen_item_t          push0,
  input  lgrs_pkg::gen_item_t          push1,
  output logic                         room,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lgrs_pkg::gen_item_t          out_item
);
  import lgrs_pkg::*;

  gen_item_t slot       [QDEPTH];
  gen_item_t slot_shift [QDEPTH];
  gen_item_t slot_next  [QDEPTH];
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic [QCNT_W-1:0] base;
  logic              pop;

  assign out_valid = (count != '0);
  assign out_item  = slot[0];
  assign pop       = out_valid && !out_stall;
  // Room for two results, so a last row can always land.
  assign room      = (count <= QCNT_W'(1));
  assign base      = count - QCNT_W'(pop);

  always_comb begin
    for (int i = 0; i < QDEPTH - 1; i++) begin
      slot_shift[i] = pop ? slot[i+1] : slot[i];
    end
    slot_shift[QDEPTH-1] = slot[QDEPTH-1];
    for (int i = 0; i < QDEPTH; i++) begin
      if (QCNT_W'(i) < base) begin
        slot_next[i] = slot_shift[i];
      end else if (QCNT_W'(i) == base) begin
        slot_next[i] = push0;
      end else if (QCNT_W'(i) == base + QCNT_W'(1)) begin
        slot_next[i] = push1;
      end else begin
        slot_next[i] = slot_shift[i];
      end
    end
    count_next = base + push_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      slot[i] <= slot_next[i];
    end
  end

endmodule

### hdl/life_generation_row_stream.sv
// Top level: life rule B3/S23 over a stream of grid rows, one column cell per bit.
//
//   channel   direction   handshake                   payload
//   row       in          row_valid / row_stall       row_data  (row_cells, last_row)
//   gen       out         gen_valid / gen_stall       gen_data  (next_row, frame_end)
//   cfg       in          cfg_write                   cfg_data  (columns_in_use)
//
// A row is taken every cycle while the result queue holds at most one entry;
// its results enter the queue at the same edge and reach gen_data after any older ones.
// A last row behind a pending row pushes two results, which the queue depth
// (three) has room for; row_stall then rises until at most one entry is left.
// Synchronous reset empties the queue, clears every column and sets the
// width to 64. gen_stall only holds the queue; the rows keep their state.
`include "assert_macros.svh"

module life_generation_row_stream (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        row_valid,
  output logic                        row_stall,
  input  lgrs_pkg::row_item_t         row_data,
  output logic                        gen_valid,
  input  logic                        gen_stall,
  output lgrs_pkg::gen_item_t         gen_data,
  input  logic                        cfg_write,
  input  logic [lgrs_pkg::COL_W-1:0]  cfg_data
);
  import lgrs_pkg::*;

  logic [COL_W-1:0] columns_in_use;
  logic             middle_valid;
  logic             accept;
  logic             room;
  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] res_a;
  logic [ROW_W-1:0] res_b;
  logic [1:0]       push_n;
  gen_item_t        push0;
  gen_item_t        push1;
  cell_bits_t       bits [ROW_W];

  // Width register; values of 64 and above open the whole row.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= COLUMNS_RESET;
    end else if (cfg_write) begin
      columns_in_use <= cfg_data;
    end
  end

  assign row_stall = !room;
  assign accept    = row_valid && !row_stall;

  // Track whether a pending row waits for the row below it.
  always_ff @(posedge clk) begin
    if (rst) begin
      middle_valid <= 1'b0;
    end else if (accept) begin
      middle_valid <= !row_data.last_row;
    end
  end

  // Chain of column cells; each shows its masked bits to both neighbors,
  // and the grid edges see dead cells.
  for (genvar i = 0; i < ROW_W; i++) begin : g_col
    cell_bits_t left_bits;
    cell_bits_t right_bits;

    assign mask[i] = (i < MAX_COLUMNS) && (columns_in_use > COL_W'(i));

    if (i == 0) begin : g_left_edge
      assign left_bits = '0;
    end else begin : g_left
      assign left_bits = bits[i-1];
    end

    if (i == ROW_W - 1) begin : g_right_edge
      assign right_bits = '0;
    end else begin : g_right
      assign right_bits = bits[i+1];
    end

    lgrs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .mask      (mask[i]),
      .row_bit   (row_data.row_cells[i]),
      .accept    (accept),
      .last      (row_data.last_row),
      .mid_valid (middle_valid),
      .left      (left_bits),
      .right     (right_bits),
      .bits      (bits[i]),
      .res_a     (res_a[i]),
      .res_b     (res_b[i])
    );
  end

  // Pending row result goes first; the last row's own result closes the frame.
  always_comb begin
    push0.next_row  = middle_valid ? res_a : res_b;
    push0.frame_end = !middle_valid;
    push1.next_row  = res_b;
    push1.frame_end = 1'b1;
    if (!accept) begin
      push_n = 2'd0;
    end else if (middle_valid && row_data.last_row) begin
      push_n = 2'd2;
    end else if (middle_valid || row_data.last_row) begin
      push_n = 2'd1;
    end else begin
      push_n = 2'd0;
    end
  end

  lgrs_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (push0),
    .push1     (push1),
    .room      (room),
    .out_valid (gen_valid),
    .out_stall (gen_stall),
    .out_item  (gen_data)
  );

  // Input stalls only while results back up in the queue.
  `LGRS_ASSERT(a_stall_needs_results, !row_stall || gen_valid, "row_stall without queued results")
  // A last row ends the frame: nothing stays pending.
  `LGRS_ASSERT_NEXT(a_last_clears, accept && row_data.last_row, !middle_valid, "pending row survived frame end")
  // Any other row becomes the pending row.
  `LGRS_ASSERT_NEXT(a_row_pends, accept && !row_data.last_row, middle_valid, "accepted row not pending")

endmodule
